/* sv/i2cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master byte engine
// Opcode and phase encodings, the decoded tick beat and the result beat.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CountW      = 4;   // bit counter holds 0..8
  localparam int unsigned QueueDepth  = 2;

  typedef logic [CountW-1:0] count_t;

  // Bus commands
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Sequencer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ONE  = 4'b0010,
    PH_TWO  = 4'b0100,
    PH_THREE = 4'b1000
  } phase_e;

  // One tick as classified by the front end
  typedef struct packed {
    logic       cmd_valid;
    op_e        opcode;
    logic [7:0] load_byte;    // tx byte for a write, zero otherwise
    logic       ack_on_read;
    logic       sda_in;
  } item_t;

  // One tick's outputs
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } res_t;

endpackage
`default_nettype wire

/* sv/i2cm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front: tick intake and classification
// Takes tick beats, decodes the command fields and holds them in a short
// queue for the bus sequencer.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       cmd_valid_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       ack_on_read_i,
  input  wire logic       sda_in_i,
  output logic            item_valid_o,
  input  wire logic       item_ready_i,
  output item_t           item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t             buf_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;
  item_t             item_dec;

  // Classify the incoming beat
  always_comb begin
    item_dec.cmd_valid   = cmd_valid_i;
    item_dec.opcode      = op_e'(opcode_i);
    item_dec.load_byte   = (op_e'(opcode_i) == OP_WRITE) ? tx_byte_i : 8'd0;
    item_dec.ack_on_read = ack_on_read_i;
    item_dec.sda_in      = sda_in_i;
  end

  assign full         = (cnt_q == CntW'(QueueDepth));
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign rd_en        = item_valid_o && item_ready_i;
  assign item_o       = buf_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_ptr_q] <= item_dec;
    end
  end

endmodule
`default_nettype wire

/* sv/i2cm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back: bus phase sequencer and result queue
// Runs one tick per beat through start, stop, write and read sequences and
// queues the drive levels and status for the consumer.
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  input  wire item_t      item_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_pull_low_o,
  output logic            sda_pull_low_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o,
  output logic            ack_bit_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Sequencer state
  op_e        cmd_q, cmd_d;
  phase_e     phase_q, phase_d;
  count_t     bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       ack_sel_q, ack_sel_d;
  logic       scl_low_q, scl_low_d;
  logic       sda_low_q, sda_low_d;
  logic       rx_ack_q, rx_ack_d;
  logic [7:0] last_rx_q, last_rx_d;
  logic       busy, done;
  logic       fire;

  // Result queue
  res_t            res_q [QueueDepth];
  res_t            res_d;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            rd_en;

  assign item_ready_o = (cnt_q != CntW'(QueueDepth));
  assign fire         = item_valid_i && item_ready_o;

  // Phase step for one tick
  always_comb begin
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    ack_sel_d = ack_sel_q;
    scl_low_d = scl_low_q;
    sda_low_d = sda_low_q;
    rx_ack_d  = rx_ack_q;
    last_rx_d = last_rx_q;
    busy      = 1'b0;
    done      = 1'b0;

    // new command is taken only when idle, and its first tick runs now
    if (phase_q == PH_IDLE && item_i.cmd_valid) begin
      cmd_d     = item_i.opcode;
      phase_d   = PH_ONE;
      bit_cnt_d = '0;
      shift_d   = item_i.load_byte;
      ack_sel_d = item_i.ack_on_read;
    end

    if (phase_d != PH_IDLE) begin
      busy = 1'b1;
      case (cmd_d)
        OP_START: begin
          case (phase_d)
            PH_ONE: begin
              scl_low_d = 1'b0;
              sda_low_d = 1'b0;
              phase_d   = PH_TWO;
            end
            PH_TWO: begin
              sda_low_d = 1'b1;
              phase_d   = PH_THREE;
            end
            PH_THREE: begin
              scl_low_d = 1'b1;
              done      = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        OP_STOP: begin
          case (phase_d)
            PH_ONE: begin
              sda_low_d = 1'b1;
              scl_low_d = 1'b1;
              phase_d   = PH_TWO;
            end
            PH_TWO: begin
              scl_low_d = 1'b0;
              phase_d   = PH_THREE;
            end
            PH_THREE: begin
              sda_low_d = 1'b0;
              done      = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (phase_d)
            PH_ONE: begin
              scl_low_d = 1'b0;
              if (bit_cnt_d < count_t'(BitsPerByte)) begin
                sda_low_d = ~shift_d[7];
              end else begin
                // ack bit: release SDA and sample the slave's answer
                sda_low_d = 1'b0;
                rx_ack_d  = item_i.sda_in;
              end
              phase_d = PH_TWO;
            end
            PH_TWO: begin
              scl_low_d = 1'b1;
              if (bit_cnt_d < count_t'(BitsPerByte)) begin
                shift_d   = {shift_d[6:0], 1'b0};
                bit_cnt_d = bit_cnt_d + 1'b1;
                phase_d   = PH_ONE;
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
        OP_READ: begin
          case (phase_d)
            PH_ONE: begin
              scl_low_d = 1'b0;
              if (bit_cnt_d < count_t'(BitsPerByte)) begin
                sda_low_d = 1'b0;
                shift_d   = {shift_d[6:0], item_i.sda_in};
                // last data bit: the assembled byte becomes visible
                if (bit_cnt_d == count_t'(BitsPerByte - 1)) begin
                  last_rx_d = shift_d;
                end
              end else begin
                sda_low_d = ack_sel_d;
              end
              phase_d = PH_TWO;
            end
            PH_TWO: begin
              scl_low_d = 1'b1;
              if (bit_cnt_d < count_t'(BitsPerByte)) begin
                bit_cnt_d = bit_cnt_d + 1'b1;
                phase_d   = PH_ONE;
              end else begin
                phase_d = PH_THREE;
              end
            end
            PH_THREE: begin
              // trailing tick: SDA pulled low after the ack bit
              sda_low_d = 1'b1;
              done      = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        default: done = 1'b1;
      endcase
      if (done) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // Result beat for this tick
  always_comb begin
    res_d.scl_pull_low = scl_low_d;
    res_d.sda_pull_low = sda_low_d;
    res_d.busy_res     = busy;
    res_d.done_res     = done;
    res_d.rx_byte      = last_rx_d;
    res_d.ack_bit      = rx_ack_d;
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= OP_START;
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      ack_sel_q <= 1'b0;
      scl_low_q <= 1'b0;
      sda_low_q <= 1'b0;
      rx_ack_q  <= 1'b0;
      last_rx_q <= '0;
    end else if (fire) begin
      cmd_q     <= cmd_d;
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      ack_sel_q <= ack_sel_d;
      scl_low_q <= scl_low_d;
      sda_low_q <= sda_low_d;
      rx_ack_q  <= rx_ack_d;
      last_rx_q <= last_rx_d;
    end
  end

  // Result queue control
  assign empty = (cnt_q == '0);
  assign rd_en = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (fire && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !fire) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q[wr_ptr_q] <= res_d;
    end
  end

  assign scl_pull_low_o = res_q[rd_ptr_q].scl_pull_low;
  assign sda_pull_low_o = res_q[rd_ptr_q].sda_pull_low;
  assign busy_res_o     = res_q[rd_ptr_q].busy_res;
  assign done_res_o     = res_q[rd_ptr_q].done_res;
  assign rx_byte_o      = res_q[rd_ptr_q].rx_byte;
  assign ack_bit_o      = res_q[rd_ptr_q].ack_bit;

endmodule
`default_nettype wire

/* sv/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: open-drain I2C master, one beat per bus delay tick
//
//   channel  | handshake          | fields
//   ---------+--------------------+-------------------------------------------
//   tick in  | push / full        | cmd_valid, opcode, tx_byte, ack_on_read,
//            |                    | sda_in
//   result   | pop / empty        | scl_pull_low, sda_pull_low, busy_res,
//            |                    | done_res, rx_byte, ack_bit
//
// One tick beat is taken per cycle while full is low and yields one result
// beat; the phase sequencer advances one step per cycle while it has a beat
// and the result queue has room. A beat's result passes through the intake
// queue, then the sequencer into the result queue, before it is on the ports.
// Reset clears both queues and the sequencer; both lines are released.
// A stalled result side fills the two-entry result queue, then the two-entry
// intake queue, and only then raises full.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       cmd_valid_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       ack_on_read_i,
  input  wire logic       sda_in_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_pull_low_o,
  output logic            sda_pull_low_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rx_byte_o,
  output logic            ack_bit_o
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Intake and classification
  i2cm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .cmd_valid_i   (cmd_valid_i),
    .opcode_i      (opcode_i),
    .tx_byte_i     (tx_byte_i),
    .ack_on_read_i (ack_on_read_i),
    .sda_in_i      (sda_in_i),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  // Bus sequencer and result queue
  i2cm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .empty          (empty),
    .pop            (pop),
    .scl_pull_low_o (scl_pull_low_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .rx_byte_o      (rx_byte_o),
    .ack_bit_o      (ack_bit_o)
  );

endmodule
`default_nettype wire

/* sv/i2cm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_checker: port-level checks for the I2C master byte engine
// Watches the top-level ports and flags result beats that break the
// sequencer's rules or the result queue's handshake.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       scl_pull_low_o,
  input wire logic       sda_pull_low_o,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic [7:0] rx_byte_o,
  input wire logic       ack_bit_o
);

  // Nothing waits on the result side once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result beat shown during reset");

  // Input only backs up behind a waiting result beat
  a_full_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full raised with the result side empty");

  // A finishing tick is always part of a running command
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && done_res_o |-> busy_res_o)
    else $error("done without busy");

  // Only stop ends with SCL released, and it leaves SDA released too
  a_done_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && done_res_o && !scl_pull_low_o |-> !sda_pull_low_o)
    else $error("command ended with SCL released and SDA held low");

  // An unpopped result beat stays and holds its contents
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rx_byte_o) && $stable(ack_bit_o)
      && $stable(busy_res_o) && $stable(done_res_o)
      && $stable(scl_pull_low_o) && $stable(sda_pull_low_o))
    else $error("result beat dropped or changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .scl_pull_low_o (scl_pull_low_o),
  .sda_pull_low_o (sda_pull_low_o),
  .busy_res_o     (busy_res_o),
  .done_res_o     (done_res_o),
  .rx_byte_o      (rx_byte_o),
  .ack_bit_o      (ack_bit_o)
);
`default_nettype wire

/* dv/i2cm_bus_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_bus_checker: scoreboard for the I2C master byte engine
// Watches the tick and result channels. Every accepted tick beat is run
// through a cycle-exact model of the bus sequencer, and the predicted line
// levels, status and captured data are queued. Each result beat is compared
// field by field with the oldest prediction. The failure count and the
// number of outstanding predictions go back to the testbench top.
// ----------------------------------------------------------------------------
module i2cm_bus_checker import i2cm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic       cmd_valid_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       ack_on_read_i,
  input  wire logic       sda_in_i,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic       scl_pull_low_i,
  input  wire logic       sda_pull_low_i,
  input  wire logic       busy_res_i,
  input  wire logic       done_res_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       ack_bit_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int unsigned ReportLimit = 10;

  // Sequencer model state
  op_e        cur_op;
  phase_e     step;
  count_t     bits_done;
  logic [7:0] shifter;
  logic       want_ack;
  logic       scl_low;
  logic       sda_low;
  logic       slave_ack;
  logic [7:0] last_read;

  res_t due_ticks[$];
  int   fails;
  int   mismatches;

  // Advance the sequencer model by one bus tick
  task automatic step_sequencer(input logic valid, input op_e op, input logic [7:0] data,
                                input logic ack, input logic sda, output res_t r);
    logic busy;
    logic done;
    busy = 1'b0;
    done = 1'b0;
    // a command is only taken while idle; offers during a command are dropped
    if (step == PH_IDLE && valid) begin
      cur_op    = op;
      step      = PH_ONE;
      bits_done = '0;
      shifter   = (op == OP_WRITE) ? data : 8'h00;
      want_ack  = ack;
    end
    if (step != PH_IDLE) begin
      busy = 1'b1;
      case (cur_op)
        OP_START: begin
          case (step)
            PH_ONE: begin
              scl_low = 1'b0;
              sda_low = 1'b0;
              step    = PH_TWO;
            end
            PH_TWO: begin
              sda_low = 1'b1;
              step    = PH_THREE;
            end
            PH_THREE: begin
              scl_low = 1'b1;
              done    = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        OP_STOP: begin
          case (step)
            PH_ONE: begin
              sda_low = 1'b1;
              scl_low = 1'b1;
              step    = PH_TWO;
            end
            PH_TWO: begin
              scl_low = 1'b0;
              step    = PH_THREE;
            end
            PH_THREE: begin
              sda_low = 1'b0;
              done    = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (step)
            PH_ONE: begin
              scl_low = 1'b0;
              if (bits_done < BitsPerByte) begin
                sda_low = ~shifter[7];
              end else begin
                // ack slot: release SDA and sample the slave
                sda_low   = 1'b0;
                slave_ack = sda;
              end
              step = PH_TWO;
            end
            PH_TWO: begin
              scl_low = 1'b1;
              if (bits_done < BitsPerByte) begin
                shifter   = {shifter[6:0], 1'b0};
                bits_done = bits_done + 1'b1;
                step      = PH_ONE;
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
        default: begin
          case (step)
            PH_ONE: begin
              scl_low = 1'b0;
              if (bits_done < BitsPerByte) begin
                sda_low = 1'b0;
                shifter = {shifter[6:0], sda};
                if (bits_done == BitsPerByte - 1) last_read = shifter;
              end else begin
                sda_low = want_ack;
              end
              step = PH_TWO;
            end
            PH_TWO: begin
              scl_low = 1'b1;
              if (bits_done < BitsPerByte) begin
                bits_done = bits_done + 1'b1;
                step      = PH_ONE;
              end else begin
                step = PH_THREE;
              end
            end
            PH_THREE: begin
              // trailing tick: SDA held low after the ack/nack bit
              sda_low = 1'b1;
              done    = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      endcase
      if (done) step = PH_IDLE;
    end
    r.scl_pull_low = scl_low;
    r.sda_pull_low = sda_low;
    r.busy_res     = busy;
    r.done_res     = done;
    r.rx_byte      = last_read;
    r.ack_bit      = slave_ack;
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      fails++;
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    end
  endtask

  // Predict on tick beats, check on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      cur_op       = OP_START;
      step         = PH_IDLE;
      bits_done    = '0;
      shifter      = 8'h00;
      want_ack     = 1'b0;
      scl_low      = 1'b0;
      sda_low      = 1'b0;
      slave_ack    = 1'b0;
      last_read    = 8'h00;
      fails        = 0;
      mismatches   = 0;
      due_ticks.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (pop && !empty) begin
        got.scl_pull_low = scl_pull_low_i;
        got.sda_pull_low = sda_pull_low_i;
        got.busy_res     = busy_res_i;
        got.done_res     = done_res_i;
        got.rx_byte      = rx_byte_i;
        got.ack_bit      = ack_bit_i;
        if (due_ticks.size() == 0) begin
          fails++;
          $display("%0t: result beat with no prediction waiting", $realtime);
        end else begin
          want = due_ticks.pop_front();
          compare_field("scl_pull_low", want.scl_pull_low, got.scl_pull_low);
          compare_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
          compare_field("busy_res",     want.busy_res,     got.busy_res);
          compare_field("done_res",     want.done_res,     got.done_res);
          compare_field("rx_byte",      want.rx_byte,      got.rx_byte);
          compare_field("ack_bit",      want.ack_bit,      got.ack_bit);
        end
      end
      if (push && !full) begin
        step_sequencer(cmd_valid_i, op_e'(opcode_i), tx_byte_i, ack_on_read_i, sda_in_i, want);
        due_ticks.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= due_ticks.size();
    end
  end

endmodule

/* dv/i2c_master_byte_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb: top-level testbench for the I2C master engine
// Drives bus ticks as whole commands: a short directed run over every
// command and the line-level corner cases, then random bus transactions
// (start, bytes written or read, stop) mixed with stray commands, busy
// offers and idle ticks. Both channels idle at random; the result side is
// held off once to back the block up. Checking lives in i2cm_bus_checker.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int unsigned RandomTicks  = 1450;
  localparam int unsigned IdlePct      = 23;
  // receiver: one long hold-off and one stretch with pop always high
  localparam int unsigned HoldFirst    = 400;
  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned PopSteadyLo  = 1500;
  localparam int unsigned PopSteadyHi  = 2300;
  // sender: stretch with no gaps, counted in beats, and one full drain
  localparam int unsigned PushSteadyLo = 900;
  localparam int unsigned PushSteadyHi = 1200;
  localparam int unsigned DrainAt      = 700;
  localparam int unsigned DrainLimit   = 100000;
  localparam int unsigned TailCycles   = 8;
  // SDA patterns during a command
  localparam int unsigned SdaLow       = 0;
  localparam int unsigned SdaHigh      = 1;
  localparam int unsigned SdaRand      = 2;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic       full;
  logic       cmd_valid_i   = 1'b0;
  logic [1:0] opcode_i      = 2'b00;
  logic [7:0] tx_byte_i     = 8'h00;
  logic       ack_on_read_i = 1'b0;
  logic       sda_in_i      = 1'b1;
  logic       empty;
  logic       pop           = 1'b0;
  logic       scl_pull_low_o;
  logic       sda_pull_low_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] rx_byte_o;
  logic       ack_bit_o;
  int         fail_count;
  int         pending;

  int unsigned ticks_sent = 0;
  bit          drained    = 1'b0;

  always #1 clk_i = ~clk_i;

  i2c_master_byte_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_valid_i    (cmd_valid_i),
    .opcode_i       (opcode_i),
    .tx_byte_i      (tx_byte_i),
    .ack_on_read_i  (ack_on_read_i),
    .sda_in_i       (sda_in_i),
    .empty          (empty),
    .pop            (pop),
    .scl_pull_low_o (scl_pull_low_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .rx_byte_o      (rx_byte_o),
    .ack_bit_o      (ack_bit_o)
  );

  i2cm_bus_checker i_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_valid_i    (cmd_valid_i),
    .opcode_i       (opcode_i),
    .tx_byte_i      (tx_byte_i),
    .ack_on_read_i  (ack_on_read_i),
    .sda_in_i       (sda_in_i),
    .empty          (empty),
    .pop            (pop),
    .scl_pull_low_i (scl_pull_low_o),
    .sda_pull_low_i (sda_pull_low_o),
    .busy_res_i     (busy_res_o),
    .done_res_i     (done_res_o),
    .rx_byte_i      (rx_byte_o),
    .ack_bit_i      (ack_bit_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result side: random pops, one long hold-off, one steady stretch
  initial begin : result_side
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HoldFirst && cyc < HoldFirst + HoldCycles) pop <= 1'b0;
      else if (cyc >= PopSteadyLo && cyc < PopSteadyHi) pop <= 1'b1;
      else pop <= ($urandom_range(99) >= IdlePct);
    end
  end

  // Offer one tick beat, with random gaps ahead of it outside the steady stretch, and wait for it to go in
  task automatic offer_tick(input logic valid, input op_e op, input logic [7:0] data,
                            input logic ack, input logic sda);
    if (!(ticks_sent >= PushSteadyLo && ticks_sent < PushSteadyHi)) begin
      while ($urandom_range(99) < IdlePct) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push          <= 1'b1;
    cmd_valid_i   <= valid;
    opcode_i      <= op;
    tx_byte_i     <= data;
    ack_on_read_i <= ack;
    sda_in_i      <= sda;
    do @(posedge clk_i); while (full);
    ticks_sent++;
  endtask

  // One command plus the ticks it runs for; noise_pct of the busy ticks carry
  // a fresh offer that the block must drop
  task automatic run_command(input op_e op, input logic [7:0] data, input logic ack,
                             input int unsigned sda_mode, input int unsigned noise_pct);
    int unsigned len;
    logic        s;
    len = (op == OP_WRITE) ? 18 : (op == OP_READ) ? 19 : 3;
    for (int unsigned k = 0; k < len; k++) begin
      s = (sda_mode == SdaLow) ? 1'b0 : (sda_mode == SdaHigh) ? 1'b1 : 1'($urandom_range(1));
      if (k == 0)
        offer_tick(1'b1, op, data, ack, s);
      else
        offer_tick(($urandom_range(99) < noise_pct), op_e'($urandom_range(3)),
                   8'($urandom_range(255)), 1'($urandom_range(1)), s);
    end
  endtask

  // Ticks with nothing offered; the other fields are junk
  task automatic idle_ticks(input int unsigned n);
    repeat (n)
      offer_tick(1'b0, op_e'($urandom_range(3)), 8'($urandom_range(255)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_sda();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return SdaLow;
    if (r == 1) return SdaHigh;
    return SdaRand;
  endfunction

  // Stimulus and verdict
  initial begin : tick_side
    int unsigned nbytes;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle lines, start with an offer on every busy tick,
    // write of all ones left unacknowledged, read of all ones with ack, stop
    idle_ticks(1);
    run_command(OP_START, 8'hFF, 1'b1, SdaRand, 100);
    run_command(OP_WRITE, 8'hFF, 1'b0, SdaHigh, 0);
    run_command(OP_READ, 8'h00, 1'b1, SdaHigh, 0);
    run_command(OP_STOP, 8'h00, 1'b0, SdaLow, 50);

    while (ticks_sent < RandomTicks + 44) begin
      // once, let every outstanding result come back before going on
      if (!drained && ticks_sent >= DrainAt) begin
        drained = 1'b1;
        push <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 85) begin
        // well-formed transaction with random content
        run_command(OP_START, pick_byte(), 1'($urandom_range(1)), pick_sda(), 25);
        nbytes = $urandom_range(4, 1);
        repeat (nbytes)
          run_command($urandom_range(1) ? OP_WRITE : OP_READ, pick_byte(),
                      1'($urandom_range(1)), pick_sda(), 25);
        run_command(OP_STOP, pick_byte(), 1'($urandom_range(1)), pick_sda(), 25);
      end else begin
        // broken sequences: a lone command, repeated starts or stray idle ticks
        case ($urandom_range(2))
          0: run_command(op_e'($urandom_range(3)), pick_byte(), 1'($urandom_range(1)),
                         pick_sda(), 40);
          1: idle_ticks($urandom_range(6, 1));
          default: begin
            run_command(OP_START, pick_byte(), 1'b0, pick_sda(), 0);
            run_command(OP_START, pick_byte(), 1'b1, pick_sda(), 0);
          end
        endcase
      end
      if ($urandom_range(3) == 0) idle_ticks($urandom_range(3, 1));
    end

    push <= 1'b0;
    @(posedge clk_i);
    for (int unsigned i = 0; i < DrainLimit && pending != 0; i++) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("i2c_master_byte_engine_tb passed");
    end else begin
      $display("i2c_master_byte_engine_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #200us;
    $display("i2c_master_byte_engine_tb failed");
    $finish;
  end

endmodule
